FILE: sv/lsrd_pkg.sv
// lsrd_pkg: shared widths, opcodes and status codes of the lifo stack unit
// used by the channel interfaces, the stack unit and its testbench
package lsrd_pkg;

   localparam int DataWidth     = 32;
   localparam int OpWidth       = 3;
   localparam int CountOutWidth = 7;
   localparam int StatusWidth   = 2;
   localparam int StackDepth    = 64;

   localparam logic [OpWidth-1:0] OpPush    = 3'd0;
   localparam logic [OpWidth-1:0] OpPop     = 3'd1;
   localparam logic [OpWidth-1:0] OpClear   = 3'd2;
   localparam logic [OpWidth-1:0] OpCount   = 3'd3;
   localparam logic [OpWidth-1:0] OpReverse = 3'd4;
   localparam logic [OpWidth-1:0] OpDup     = 3'd5;

   localparam logic [StatusWidth-1:0] StatusOk    = 2'd0;
   localparam logic [StatusWidth-1:0] StatusEmpty = 2'd1;
   localparam logic [StatusWidth-1:0] StatusFull  = 2'd2;

   // value returned by a pop of an empty stack
   localparam logic signed [DataWidth-1:0] EmptyPopValue = '1;

endpackage

FILE: sv/lsrd_ifs.sv
// lsrd_req_if / lsrd_rsp_if: valid/ready channels of the lifo stack unit
// depends on lsrd_pkg for the payload widths
interface lsrd_req_if;
   import lsrd_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [OpWidth-1:0]          opcode;
   logic signed [DataWidth-1:0] push_value;

   modport source (output valid, output opcode, output push_value, input ready);
   modport sink (input valid, input opcode, input push_value, output ready);
endinterface

interface lsrd_rsp_if;
   import lsrd_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [DataWidth-1:0] result_value;
   logic [CountOutWidth-1:0]    fill_count;
   logic [StatusWidth-1:0]      status;

   modport source (output valid, output result_value, output fill_count, output status,
                   input ready);
   modport sink (input valid, input result_value, input fill_count, input status,
                 output ready);
endinterface

FILE: sv/lsrd_ram.sv
// lsrd_ram: generic single-write, single-read ram with registered read data
// no dependencies; contents are undefined until written
module lsrd_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/lifo_stack_with_reverse_dup_unit.sv
// Bounded lifo stack of signed 32-bit values with push, pop, clear, count,
// reverse and duplicate-top opcodes; every request beat yields one response
// beat with the value, the fill count after the operation and a status. The
// entries sit in a circular ram of Depth words; a base index and a direction
// bit make reverse a constant-time flip. Push, clear, count, reverse, the
// unused opcodes and any pop or duplicate that finds the stack empty or full
// load their response when accepted; a pop or duplicate that reads an entry
// first waits in the read state for the registered stack ram read. A finished
// response waits in an output register, and the next request is taken in the
// same cycle that register is emptied. No clearing pass follows reset.
// depends on lsrd_pkg, lsrd_ifs and lsrd_ram
module lifo_stack_with_reverse_dup_unit #(
   parameter int Depth = lsrd_pkg::StackDepth
) (
   input logic       clock,
   input logic       reset,
   lsrd_req_if.sink  req_bus,
   lsrd_rsp_if.source rsp_bus
);
   import lsrd_pkg::*;

   localparam int AddrW  = $clog2(Depth);
   localparam int SumW   = AddrW + 1;
   localparam int CountW = $clog2(Depth + 1);

   localparam logic StIdle = 1'b0;
   localparam logic StRead = 1'b1;

   function automatic logic [AddrW-1:0] wrap_add(input logic [AddrW-1:0] a,
                                                input logic [AddrW-1:0] b);
      logic [SumW-1:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= SumW'(Depth)) begin
         sum = sum - SumW'(Depth);
      end
      return sum[AddrW-1:0];
   endfunction

   logic              state_ff, state_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [AddrW-1:0]  base_ff, base_in;
   logic              rev_ff, rev_in;
   logic [AddrW-1:0]  wr_slot_ff, wr_slot_in;
   logic              pend_dup_ff, pend_dup_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [DataWidth-1:0] rsp_value_ff, rsp_value_in;
   logic [CountOutWidth-1:0]    rsp_count_ff, rsp_count_in;
   logic [StatusWidth-1:0]      rsp_status_ff, rsp_status_in;

   logic                 accept;
   logic                 empty;
   logic                 full;
   logic [CountW-1:0]    count_m1;
   logic [AddrW-1:0]     top_slot;
   logic [AddrW-1:0]     push_slot;
   logic [AddrW-1:0]     push_base;
   logic                 ram_we;
   logic [AddrW-1:0]     ram_waddr;
   logic [DataWidth-1:0] ram_wdata;
   logic [DataWidth-1:0] ram_rdata;

   assign accept   = req_bus.valid && req_bus.ready;
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CountW'(Depth));
   assign count_m1 = count_ff - CountW'(1);

   // top sits at base when reversed, else at base + count - 1
   assign top_slot  = rev_ff ? base_ff : wrap_add(base_ff, count_m1[AddrW-1:0]);
   assign push_base = wrap_add(base_ff, AddrW'(Depth - 1));
   assign push_slot = rev_ff ? push_base : wrap_add(base_ff, count_ff[AddrW-1:0]);

   assign req_bus.ready = (state_ff == StIdle) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      base_in       = base_ff;
      rev_in        = rev_ff;
      wr_slot_in    = wr_slot_ff;
      pend_dup_in   = pend_dup_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = push_slot;
      ram_wdata     = req_bus.push_value;

      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               // most opcodes finish now; reads defer the response to the read state
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = StatusOk;
               unique case (req_bus.opcode)
                  OpPush: begin
                     if (full) begin
                        rsp_status_in = StatusFull;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CountW'(1);
                        if (rev_ff) begin
                           base_in = push_base;
                        end
                     end
                  end
                  OpPop: begin
                     if (empty) begin
                        rsp_value_in  = EmptyPopValue;
                        rsp_status_in = StatusEmpty;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = StRead;
                        pend_dup_in  = 1'b0;
                        count_in     = count_m1;
                        if (rev_ff) begin
                           base_in = wrap_add(base_ff, AddrW'(1));
                        end
                     end
                  end
                  OpClear: begin
                     count_in = '0;
                     base_in  = '0;
                     rev_in   = 1'b0;
                  end
                  OpCount: begin
                  end
                  OpReverse: begin
                     if (empty) begin
                        rsp_status_in = StatusEmpty;
                     end else begin
                        rev_in = !rev_ff;
                     end
                  end
                  OpDup: begin
                     if (full) begin
                        rsp_status_in = StatusFull;
                     end else if (!empty) begin
                        rsp_valid_in = 1'b0;
                        state_in     = StRead;
                        pend_dup_in  = 1'b1;
                        wr_slot_in   = push_slot;
                        count_in     = count_ff + CountW'(1);
                        if (rev_ff) begin
                           base_in = push_base;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = CountOutWidth'(count_in);
            end
         end
         StRead: begin
            // top entry has arrived from the ram
            state_in      = StIdle;
            rsp_valid_in  = 1'b1;
            rsp_status_in = StatusOk;
            rsp_count_in  = CountOutWidth'(count_ff);
            if (pend_dup_ff) begin
               ram_we       = 1'b1;
               ram_waddr    = wr_slot_ff;
               ram_wdata    = ram_rdata;
               rsp_value_in = '0;
            end else begin
               rsp_value_in = ram_rdata;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         count_ff     <= '0;
         base_ff      <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         base_ff      <= base_in;
         rev_ff       <= rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wr_slot_ff    <= wr_slot_in;
      pend_dup_ff   <= pend_dup_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   lsrd_ram #(
      .Width (DataWidth),
      .Depth (Depth)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (top_slot),
      .rd_data (ram_rdata)
   );

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_value = rsp_value_ff;
   assign rsp_bus.fill_count   = rsp_count_ff;
   assign rsp_bus.status       = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(Depth))
      else $error("stack count beyond depth");

   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == StRead |=> state_ff == StIdle && rsp_valid_ff)
      else $error("read did not finish with a response beat");

   a_no_take_while_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("request taken while response register is blocked");

   a_clear_resets_pointers: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.opcode == OpClear |=> count_ff == '0 && base_ff == '0 && !rev_ff)
      else $error("clear left pointer state behind");

   a_idle_after_pop_empty: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.opcode == OpPop && empty |=> state_ff == StIdle && rsp_valid_ff)
      else $error("empty pop did not answer at once");
`endif

endmodule

FILE: tb/lifo_stack_with_reverse_dup_unit_checker.sv
`timescale 1ns / 1ps
// lsrd_stack_checker: watches both channels of the lifo stack unit, predicts
// each response beat from its own copy of the stack and compares field by field
// depends on lsrd_pkg and lsrd_ifs
module lsrd_stack_checker (
   input  logic       clock,
   input  logic       reset,
   lsrd_req_if        req_bus,
   lsrd_rsp_if        rsp_bus,
   output int         outstanding,
   output int         fail_count
);
   import lsrd_pkg::*;

   typedef struct packed {
      logic signed [DataWidth-1:0] value;
      logic [CountOutWidth-1:0]    fill;
      logic [StatusWidth-1:0]      status;
   } stack_rsp_type;

   // shadow stack: circular store, base slot and direction bit
   logic signed [DataWidth-1:0] shadow_slots [StackDepth];
   int                          shadow_held;
   int                          shadow_base;
   bit                          shadow_flipped;

   stack_rsp_type expected_rsps [$];

   function automatic int top_slot();
      if (shadow_flipped)
         return shadow_base;
      return (shadow_base + shadow_held - 1) % StackDepth;
   endfunction

   function automatic void place_on_top(logic signed [DataWidth-1:0] v);
      if (shadow_flipped) begin
         shadow_base = (shadow_base + StackDepth - 1) % StackDepth;
         shadow_slots[shadow_base] = v;
      end else begin
         shadow_slots[(shadow_base + shadow_held) % StackDepth] = v;
      end
      shadow_held++;
   endfunction

   function automatic stack_rsp_type apply_stack_op(logic [OpWidth-1:0] op,
                                                    logic signed [DataWidth-1:0] v);
      stack_rsp_type r;
      r.value  = '0;
      r.status = StatusOk;
      case (op)
         OpPush: begin
            if (shadow_held >= StackDepth)
               r.status = StatusFull;
            else
               place_on_top(v);
         end
         OpPop: begin
            if (shadow_held == 0) begin
               r.value  = EmptyPopValue;
               r.status = StatusEmpty;
            end else begin
               r.value = shadow_slots[top_slot()];
               if (shadow_flipped)
                  shadow_base = (shadow_base + 1) % StackDepth;
               shadow_held--;
            end
         end
         OpClear: begin
            shadow_held    = 0;
            shadow_base    = 0;
            shadow_flipped = 0;
         end
         OpReverse: begin
            if (shadow_held == 0)
               r.status = StatusEmpty;
            else
               shadow_flipped = !shadow_flipped;
         end
         OpDup: begin
            // empty stack: nothing happens and status stays ok
            if (shadow_held != 0) begin
               if (shadow_held >= StackDepth)
                  r.status = StatusFull;
               else
                  place_on_top(shadow_slots[top_slot()]);
            end
         end
         default: ;
      endcase
      r.fill = CountOutWidth'(shadow_held);
      return r;
   endfunction

   always @(posedge clock) begin
      stack_rsp_type want;
      int            errs;
      errs = 0;
      if (reset) begin
         expected_rsps.delete();
         shadow_held    = 0;
         shadow_base    = 0;
         shadow_flipped = 0;
         outstanding <= 0;
         fail_count  <= 0;
      end else begin
         // response side first: a beat accepted now cannot answer this edge's request
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: response beat with nothing expected, actual value %0d",
                        $time, rsp_bus.result_value);
               errs++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_bus.result_value !== want.value) begin
                  $display("%0t: result_value expected %0d actual %0d",
                           $time, want.value, rsp_bus.result_value);
                  errs++;
               end
               if (rsp_bus.fill_count !== want.fill) begin
                  $display("%0t: fill_count expected %0d actual %0d",
                           $time, want.fill, rsp_bus.fill_count);
                  errs++;
               end
               if (rsp_bus.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_bus.status);
                  errs++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_rsps.push_back(apply_stack_op(req_bus.opcode, req_bus.push_value));
         fail_count  <= fail_count + errs;
         outstanding <= expected_rsps.size();
      end
   end

endmodule

FILE: tb/lifo_stack_with_reverse_dup_unit_tb.sv
`timescale 1ns / 1ps
// lifo_stack_with_reverse_dup_unit_tb: drives opcodes into the lifo stack unit
// with random gaps and back-pressure; lsrd_stack_checker does the checking
// depends on lsrd_pkg, lsrd_ifs, lsrd_stack_checker and the unit itself
module lifo_stack_with_reverse_dup_unit_tb;
   import lsrd_pkg::*;

   localparam int CycleLimit   = 200000;
   localparam int RandomBeats  = 1430;
   localparam int SegmentBeats = 60;

   // opcodes the unit ignores
   localparam logic [OpWidth-1:0] OpSpareA = 3'd6;
   localparam logic [OpWidth-1:0] OpSpareB = 3'd7;

   localparam logic signed [DataWidth-1:0] MaxValue = 32'sh7fff_ffff;
   localparam logic signed [DataWidth-1:0] MinValue = 32'sh8000_0000;

   // traffic mix of one random segment
   typedef enum logic [1:0] {
      MixFill,
      MixBalanced,
      MixDrain
   } mix_type;

   logic clock = 1'b0;
   logic reset;
   logic steady;
   int   outstanding;
   int   fail_count;
   int   cycles = 0;

   lsrd_req_if req_bus ();
   lsrd_rsp_if rsp_bus ();

   lifo_stack_with_reverse_dup_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   lsrd_stack_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("[lifo_stack_with_reverse_dup_unit] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 33);
   end

   task automatic send_beat(logic [OpWidth-1:0] op, logic signed [DataWidth-1:0] v);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.push_value <= v;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   initial begin
      logic [OpWidth-1:0]          op;
      logic signed [DataWidth-1:0] v;
      mix_type                     mix;
      int                          pick;

      reset              <= 1'b1;
      steady             <= 1'b0;
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= OpCount;
      req_bus.push_value <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty-stack cases, extremes, direction flips
      send_beat(OpPop, '0);
      send_beat(OpReverse, '0);
      send_beat(OpDup, '0);
      send_beat(OpCount, MaxValue);
      send_beat(OpPush, MaxValue);
      send_beat(OpPush, MinValue);
      send_beat(OpPush, '0);
      send_beat(OpPush, -32'sd1);
      send_beat(OpDup, '0);
      send_beat(OpCount, '0);
      send_beat(OpReverse, '0);
      send_beat(OpPop, '0);
      send_beat(OpPop, '0);
      send_beat(OpPush, 32'sh5555_5555);
      send_beat(OpDup, '0);
      send_beat(OpReverse, '0);
      send_beat(OpPop, '0);
      send_beat(OpSpareA, MinValue);
      send_beat(OpSpareB, MaxValue);
      send_beat(OpClear, '0);
      send_beat(OpPop, '0);
      send_beat(OpReverse, '0);
      send_beat(OpPush, 32'shaaaa_aaaa);
      send_beat(OpPop, '0);

      // random: segments cycle fill, fill, balanced, drain so the stack keeps
      // reaching full and empty
      for (int i = 0; i < RandomBeats; i++) begin
         if (i == 300)
            steady <= 1'b1;
         else if (i == 600)
            steady <= 1'b0;
         if (i == 900) begin
            // hold off until every response has drained
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (outstanding != 0)
               @(posedge clock);
         end
         case ((i / SegmentBeats) % 4)
            0, 1:    mix = MixFill;
            2:       mix = MixBalanced;
            default: mix = MixDrain;
         endcase
         pick = $urandom_range(0, 99);
         case (mix)
            MixFill: begin
               if (pick < 60)      op = OpPush;
               else if (pick < 75) op = OpDup;
               else if (pick < 85) op = OpPop;
               else if (pick < 93) op = OpReverse;
               else if (pick < 97) op = OpCount;
               else                op = (pick & 1) ? OpSpareA : OpSpareB;
            end
            MixBalanced: begin
               if (pick < 35)      op = OpPush;
               else if (pick < 45) op = OpDup;
               else if (pick < 75) op = OpPop;
               else if (pick < 85) op = OpReverse;
               else if (pick < 92) op = OpCount;
               else if (pick < 94) op = OpClear;
               else if (pick < 97) op = (pick & 1) ? OpSpareA : OpSpareB;
               else                op = OpPop;
            end
            default: begin
               if (pick < 20)      op = OpPush;
               else if (pick < 25) op = OpDup;
               else if (pick < 75) op = OpPop;
               else if (pick < 85) op = OpReverse;
               else if (pick < 93) op = OpCount;
               else if (pick < 95) op = OpClear;
               else                op = (pick & 1) ? OpSpareA : OpSpareB;
            end
         endcase
         case ($urandom_range(0, 19))
            0:       v = MaxValue;
            1:       v = MinValue;
            2:       v = '0;
            3:       v = -32'sd1;
            default: v = $urandom;
         endcase
         send_beat(op, v);
      end
      req_bus.valid <= 1'b0;

      while (outstanding != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("[lifo_stack_with_reverse_dup_unit] OK");
      else
         $display("[lifo_stack_with_reverse_dup_unit] ERROR");
      $finish;
   end

endmodule
